FILE: rtl/jbt_pkg.sv
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types, codes and character helpers for the byte-serial JSON lexer.
// ----------------------------------------------------------------------------
package jbt_pkg;

    // result queue depth, room for two results per item plus slack
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // token kinds
    localparam logic [3:0] KIND_LBRACE = 4'd0;
    localparam logic [3:0] KIND_STRING = 4'd6;
    localparam logic [3:0] KIND_NUMBER = 4'd7;
    localparam logic [3:0] KIND_TRUE   = 4'd8;

    // symbol lookup result for a byte that is not a structural symbol
    localparam logic [2:0] SYM_NONE = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_ESCAPE = 3'd1;
    localparam logic [2:0] ERR_END_ESC    = 3'd2;
    localparam logic [2:0] ERR_UNTERM_STR = 3'd3;
    localparam logic [2:0] ERR_BAD_NUMBER = 3'd4;
    localparam logic [2:0] ERR_BAD_KW     = 3'd5;
    localparam logic [2:0] ERR_BAD_SYMBOL = 3'd6;

    // keyword choices
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    typedef enum logic [3:0] {
        M_IDLE = 4'd0,
        M_STR  = 4'd1,
        M_ESC  = 4'd2,
        N_SIGN = 4'd3,
        N_ZERO = 4'd4,
        N_INT  = 4'd5,
        N_DOT  = 4'd6,
        N_FRAC = 4'd7,
        N_E    = 4'd8,
        N_ESGN = 4'd9,
        N_EXP  = 4'd10,
        M_KW   = 4'd11,
        M_ERR  = 4'd12
    } mode_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       cv;
        logic       st;
        logic       en;
        logic [2:0] err;
        logic       done;
        logic       last;
    } res_t;

    // up to two results for one item
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } res_pair_t;

    function automatic res_t mk_res(logic [3:0] kind, logic [7:0] ch, logic cv,
                                    logic st, logic en, logic [2:0] err,
                                    logic done);
        res_t r;
        r.kind = kind;
        r.ch   = ch;
        r.cv   = cv;
        r.st   = st;
        r.en   = en;
        r.err  = err;
        r.done = done;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic logic is_ws(logic [7:0] b);
        return (b == 8'h20) || (b inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return (b inside {["a":"z"]}) || (b inside {["A":"Z"]});
    endfunction

    function automatic logic [2:0] symbol_kind(logic [7:0] b);
        logic [2:0] s;
        case (b)
            "{":     s = 3'd0;
            "}":     s = 3'd1;
            ",":     s = 3'd2;
            ":":     s = 3'd3;
            "[":     s = 3'd4;
            "]":     s = 3'd5;
            default: s = SYM_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] kw_len(logic [1:0] c);
        logic [2:0] n;
        case (c)
            KW_TRUE:  n = 3'd4;
            KW_FALSE: n = 3'd5;
            KW_NULL:  n = 3'd4;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    // expected character at a position of the chosen keyword
    function automatic logic [7:0] kw_char(logic [1:0] c, logic [2:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        case (c)
            KW_TRUE:
                case (p)
                    3'd0:    ch = "t";
                    3'd1:    ch = "r";
                    3'd2:    ch = "u";
                    3'd3:    ch = "e";
                    default: ch = 8'h00;
                endcase
            KW_FALSE:
                case (p)
                    3'd0:    ch = "f";
                    3'd1:    ch = "a";
                    3'd2:    ch = "l";
                    3'd3:    ch = "s";
                    3'd4:    ch = "e";
                    default: ch = 8'h00;
                endcase
            KW_NULL:
                case (p)
                    3'd0:    ch = "n";
                    3'd1:    ch = "u";
                    3'd2:    ch = "l";
                    3'd3:    ch = "l";
                    default: ch = 8'h00;
                endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // {ok, decoded character}
    function automatic logic [8:0] unescape(logic [7:0] b);
        logic [8:0] v;
        case (b)
            "\"":    v = {1'b1, 8'h22};
            "\\":    v = {1'b1, 8'h5c};
            "/":     v = {1'b1, 8'h2f};
            "b":     v = {1'b1, 8'h08};
            "f":     v = {1'b1, 8'h0c};
            "n":     v = {1'b1, 8'h0a};
            "r":     v = {1'b1, 8'h0d};
            "t":     v = {1'b1, 8'h09};
            default: v = 9'h000;
        endcase
        return v;
    endfunction

    function automatic logic is_num_mode(mode_t m);
        return m inside {[N_SIGN:N_EXP]};
    endfunction

    // number grammar step, M_ERR on a character outside the grammar
    function automatic mode_t num_next(mode_t m, logic [7:0] b);
        logic  d;
        logic  e;
        mode_t v;
        d = is_digit(b);
        e = (b == "e") || (b == "E");
        case (m)
            N_SIGN:  v = (b == "0") ? N_ZERO : (d ? N_INT : M_ERR);
            N_ZERO:  v = (b == ".") ? N_DOT : (e ? N_E : M_ERR);
            N_INT:   v = d ? N_INT : ((b == ".") ? N_DOT : (e ? N_E : M_ERR));
            N_DOT:   v = d ? N_FRAC : M_ERR;
            N_FRAC:  v = d ? N_FRAC : (e ? N_E : M_ERR);
            N_E:     v = ((b == "+") || (b == "-")) ? N_ESGN : (d ? N_EXP : M_ERR);
            N_ESGN:  v = d ? N_EXP : M_ERR;
            N_EXP:   v = d ? N_EXP : M_ERR;
            default: v = M_ERR;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/jbt_lexer.sv
// ----------------------------------------------------------------------------
// jbt_lexer
// Lexer state and the single-pass decode of one item into up to two results.
// ----------------------------------------------------------------------------
module jbt_lexer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        byte_in,
    input  logic              eoi,
    output jbt_pkg::res_pair_t pair
);
    import jbt_pkg::*;

    mode_t      mode_reg,  mode_next;
    logic [1:0] kw_choice_reg, kw_choice_next;
    logic [2:0] kw_pos_reg,    kw_pos_next;
    logic [2:0] lat_err_reg,   lat_err_next;

    logic [2:0] sym;
    logic [2:0] klen;
    logic [8:0] unesc;
    mode_t      nn;
    logic       close_ok;
    res_t       close_res;
    res_t       r0;
    res_t       r1;
    logic [1:0] n;

    assign sym   = symbol_kind(byte_in);
    assign klen  = kw_len(kw_choice_reg);
    assign unesc = unescape(byte_in);
    assign nn    = num_next(mode_reg, byte_in);

    // closing a pending number or keyword
    always_comb
    begin
        close_ok  = 1'b0;
        close_res = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b0, ERR_BAD_KW, 1'b0);
        if (is_num_mode(mode_reg))
        begin
            if (mode_reg inside {N_ZERO, N_INT, N_FRAC, N_EXP})
            begin
                close_ok  = 1'b1;
                close_res = mk_res(KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
            end
            else
            begin
                close_res = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b0,
                                   ERR_BAD_NUMBER, 1'b0);
            end
        end
        else if ((klen != 3'd0) && (kw_pos_reg == klen))
        begin
            close_ok  = 1'b1;
            close_res = mk_res(KIND_TRUE + {2'b00, kw_choice_reg}, 8'h00, 1'b0,
                               1'b1, 1'b1, ERR_NONE, 1'b0);
        end
    end

    // next state and results for the item
    always_comb
    begin
        mode_next      = mode_reg;
        kw_choice_next = kw_choice_reg;
        kw_pos_next    = kw_pos_reg;
        lat_err_next   = lat_err_reg;
        r0             = '0;
        r1             = '0;
        n              = 2'd0;

        if (eoi)
        begin
            // end item: flush pending token, then done
            if (mode_reg == M_STR)
            begin
                r0           = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b0,
                                      ERR_UNTERM_STR, 1'b0);
                lat_err_next = ERR_UNTERM_STR;
                n            = 2'd1;
            end
            else if (mode_reg == M_ESC)
            begin
                r0           = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b0,
                                      ERR_END_ESC, 1'b0);
                lat_err_next = ERR_END_ESC;
                n            = 2'd1;
            end
            else if (is_num_mode(mode_reg) || (mode_reg == M_KW))
            begin
                r0 = close_res;
                if (!close_ok)
                begin
                    lat_err_next = close_res.err;
                end
                n = 2'd1;
            end
            if (n == 2'd0)
            begin
                r0 = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b0, lat_err_next, 1'b1);
                n  = 2'd1;
            end
            else
            begin
                r1 = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b0, lat_err_next, 1'b1);
                n  = 2'd2;
            end
            mode_next      = M_IDLE;
            kw_choice_next = KW_TRUE;
            kw_pos_next    = 3'd0;
            lat_err_next   = ERR_NONE;
        end
        else
        begin
            case (mode_reg)
                M_IDLE:
                begin
                    if (is_ws(byte_in))
                    begin
                        n = 2'd0;
                    end
                    else if (byte_in == "\"")
                    begin
                        r0        = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0,
                                           ERR_NONE, 1'b0);
                        n         = 2'd1;
                        mode_next = M_STR;
                    end
                    else if ((byte_in == "-") || is_digit(byte_in))
                    begin
                        r0 = mk_res(KIND_NUMBER, byte_in, 1'b1, 1'b1, 1'b0,
                                    ERR_NONE, 1'b0);
                        n  = 2'd1;
                        if (byte_in == "-")
                        begin
                            mode_next = N_SIGN;
                        end
                        else if (byte_in == "0")
                        begin
                            mode_next = N_ZERO;
                        end
                        else
                        begin
                            mode_next = N_INT;
                        end
                    end
                    else if (is_alpha(byte_in))
                    begin
                        if ((byte_in == "t") || (byte_in == "f") || (byte_in == "n"))
                        begin
                            if (byte_in == "t")
                            begin
                                kw_choice_next = KW_TRUE;
                            end
                            else if (byte_in == "f")
                            begin
                                kw_choice_next = KW_FALSE;
                            end
                            else
                            begin
                                kw_choice_next = KW_NULL;
                            end
                            kw_pos_next = 3'd1;
                            mode_next   = M_KW;
                        end
                        else
                        begin
                            r0           = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b0,
                                                  ERR_BAD_KW, 1'b0);
                            n            = 2'd1;
                            lat_err_next = ERR_BAD_KW;
                            mode_next    = M_ERR;
                        end
                    end
                    else if (sym != SYM_NONE)
                    begin
                        r0 = mk_res({1'b0, sym}, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE, 1'b0);
                        n  = 2'd1;
                    end
                    else
                    begin
                        r0           = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b0,
                                              ERR_BAD_SYMBOL, 1'b0);
                        n            = 2'd1;
                        lat_err_next = ERR_BAD_SYMBOL;
                        mode_next    = M_ERR;
                    end
                end
                M_STR:
                begin
                    if (byte_in == "\"")
                    begin
                        r0        = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1,
                                           ERR_NONE, 1'b0);
                        n         = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (byte_in == "\\")
                    begin
                        mode_next = M_ESC;
                    end
                    else
                    begin
                        r0 = mk_res(KIND_STRING, byte_in, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
                        n  = 2'd1;
                    end
                end
                M_ESC:
                begin
                    n = 2'd1;
                    if (unesc[8])
                    begin
                        r0        = mk_res(KIND_STRING, unesc[7:0], 1'b1, 1'b0, 1'b0,
                                           ERR_NONE, 1'b0);
                        mode_next = M_STR;
                    end
                    else
                    begin
                        r0           = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b0,
                                              ERR_BAD_ESCAPE, 1'b0);
                        lat_err_next = ERR_BAD_ESCAPE;
                        mode_next    = M_ERR;
                    end
                end
                N_SIGN, N_ZERO, N_INT, N_DOT, N_FRAC, N_E, N_ESGN, N_EXP, M_KW:
                begin
                    if (is_ws(byte_in) || (sym != SYM_NONE))
                    begin
                        // terminator closes the token, a symbol follows it
                        r0 = close_res;
                        n  = 2'd1;
                        if (close_ok)
                        begin
                            mode_next = M_IDLE;
                            if (mode_reg == M_KW)
                            begin
                                kw_pos_next = 3'd0;
                            end
                            if (sym != SYM_NONE)
                            begin
                                r1 = mk_res({1'b0, sym}, 8'h00, 1'b0, 1'b1, 1'b1,
                                            ERR_NONE, 1'b0);
                                n  = 2'd2;
                            end
                        end
                        else
                        begin
                            lat_err_next = close_res.err;
                            mode_next    = M_ERR;
                        end
                    end
                    else if (mode_reg == M_KW)
                    begin
                        if ((kw_pos_reg < klen) &&
                            (byte_in == kw_char(kw_choice_reg, kw_pos_reg)))
                        begin
                            kw_pos_next = kw_pos_reg + 3'd1;
                        end
                        else
                        begin
                            r0           = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b0,
                                                  ERR_BAD_KW, 1'b0);
                            n            = 2'd1;
                            lat_err_next = ERR_BAD_KW;
                            mode_next    = M_ERR;
                        end
                    end
                    else if (nn == M_ERR)
                    begin
                        r0           = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b0, 1'b0,
                                              ERR_BAD_NUMBER, 1'b0);
                        n            = 2'd1;
                        lat_err_next = ERR_BAD_NUMBER;
                        mode_next    = M_ERR;
                    end
                    else
                    begin
                        r0        = mk_res(KIND_NUMBER, byte_in, 1'b1, 1'b0, 1'b0,
                                           ERR_NONE, 1'b0);
                        n         = 2'd1;
                        mode_next = nn;
                    end
                end
                default:
                begin
                    // error latched: bytes ignored until the end item
                    n = 2'd0;
                end
            endcase
        end

        // mark the last result of the item
        if (n == 2'd1)
        begin
            r0.last = 1'b1;
        end
        else if (n == 2'd2)
        begin
            r1.last = 1'b1;
        end
    end

    assign pair.n  = n;
    assign pair.r0 = r0;
    assign pair.r1 = r1;

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            kw_choice_reg <= KW_TRUE;
            kw_pos_reg    <= 3'd0;
            lat_err_reg   <= ERR_NONE;
        end
        else if (take)
        begin
            mode_reg      <= mode_next;
            kw_choice_reg <= kw_choice_next;
            kw_pos_reg    <= kw_pos_next;
            lat_err_reg   <= lat_err_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_err_only_in_err_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (lat_err_reg != ERR_NONE) |-> (mode_reg == M_ERR))
        else $error("error latched outside error mode");

    a_kw_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_KW) |-> ((kw_pos_reg >= 3'd1) && (kw_pos_reg <= 3'd5)
                                && (kw_choice_reg != 2'd3)))
        else $error("keyword position out of range");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (take && eoi) |=> ((mode_reg == M_IDLE) && (lat_err_reg == ERR_NONE)
                           && (kw_pos_reg == 3'd0)))
        else $error("end item did not return lexer to idle");
`endif

endmodule

FILE: rtl/jbt_result_fifo.sv
// ----------------------------------------------------------------------------
// jbt_result_fifo
// Small result queue: up to two results written per cycle, one read per cycle.
// ----------------------------------------------------------------------------
module jbt_result_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  jbt_pkg::res_pair_t pair,
    output logic               space_ok,
    output logic               out_valid,
    input  logic               out_ready,
    output jbt_pkg::res_t      head
);
    import jbt_pkg::*;

    res_t                mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic [QCNT_W-1:0]   count_after_pop;
    logic [1:0]          push_n;
    logic                pop;

    // pop and free space
    assign out_valid       = (count_reg != '0);
    assign head            = mem_reg[rd_ptr_reg];
    assign pop             = out_valid && out_ready;
    assign count_after_pop = count_reg - QCNT_W'(pop);
    assign space_ok        = (count_after_pop <= QCNT_W'(QDEPTH - 2));
    assign push_n          = take ? pair.n : 2'd0;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_after_pop + QCNT_W'(push_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= pair.r0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_reg + QPTR_W'(1)] <= pair.r1;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> (count_after_pop <= QCNT_W'(QDEPTH - 2)))
        else $error("push without room for two results");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (push_n == 2'd0)) |=> (count_reg == $past(count_reg) - QCNT_W'(1)))
        else $error("fill count wrong after read");
`endif

endmodule

FILE: rtl/json_byte_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// json_byte_tokenizer_unit
// Byte-serial JSON lexer: one byte item in, zero to two token results out.
// ----------------------------------------------------------------------------
// One input byte a cycle is taken while the queue has room. Each item passes
// through an input register and one pass of decode logic into a four-entry
// result queue. The queue delivers one result a cycle while out_ready is
// high, so an item that gives two results (a number or keyword ended by a
// symbol, or an end item that closes a pending token) is delivered in two
// turns; a new item is decoded whenever the queue has room for two results,
// and items giving no result (whitespace, keyword letters) take no queue
// entry. An error gives one error result, and every later byte is dropped
// until the end item, which always gives a final done result with the error.
module json_byte_tokenizer_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] token_kind,
    output logic [7:0] char_out,
    output logic       char_valid,
    output logic       token_start,
    output logic       token_end,
    output logic [2:0] error_code,
    output logic       stream_done,
    output logic       last_of_run
);
    import jbt_pkg::*;

    logic       hold_valid_reg;
    logic [7:0] byte_reg;
    logic       eoi_reg;
    logic       take;
    logic       space_ok;
    res_pair_t  pair;
    res_t       head;

    // input register, refilled as soon as its item is decoded
    assign take     = hold_valid_reg && space_ok;
    assign in_ready = !hold_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            eoi_reg  <= end_of_input;
        end
    end

    // decode
    jbt_lexer u_lexer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .byte_in (byte_reg),
        .eoi     (eoi_reg),
        .pair    (pair)
    );

    // result queue
    jbt_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .pair      (pair),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // result fields
    assign token_kind  = head.kind;
    assign char_out    = head.ch;
    assign char_valid  = head.cv;
    assign token_start = head.st;
    assign token_end   = head.en;
    assign error_code  = head.err;
    assign stream_done = head.done;
    assign last_of_run = head.last;

endmodule
